>>> rtl/srfp_pkg.sv
// Package for the sensor response frame parser.
// Holds the field widths, status and register codes, and the structs passed between
// the front, the job queue and the back. No dependencies.
package srfp_pkg;

    // Field widths of the result item.
    localparam int IDX_W    = 4;
    localparam int WORD_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;

    // Bytes in the frame header (start, command, two size bytes).
    localparam int HDR_LEN = 4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_HDR_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CHK_ERR = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_CMD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_HI    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED       = 3'd4;

    // Job queue between front and back.
    localparam int JOBQ_DEPTH = 4;
    localparam int JOBQ_PTR_W = 2;
    localparam int JOBQ_CNT_W = 3;

    // One finished frame (or header error) handed from the front to the back.
    typedef struct packed {
        logic hdr_err;
        logic chk_err;
        logic bank;
    } t_job;

    // Word store write from the front.
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [IDX_W-1:0]  addr;
        logic [WORD_W-1:0] data;
    } t_store_wr;

    // Bank release from the back once its last word has been loaded for output.
    typedef struct packed {
        logic en;
        logic bank;
    } t_bank_rel;

endpackage

>>> rtl/sensor_response_frame_parser_core.sv
// Top level of the sensor response frame parser: configuration registers, front parser,
// job queue and result back end. Depends on srfp_pkg, srfp_front, srfp_job_queue, srfp_back.
//
//  Channel  Direction  Handshake                  Payload
//  -------  ---------  -------------------------  ------------------------------------------
//  in       input      i_in_valid / o_in_stall    i_rx_byte
//  out      output     o_out_valid / i_out_stall  o_word_index, o_word_value,
//                                                 o_frame_status, o_last_of_frame
//  cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One byte is taken per cycle; each byte finishes in the front in the cycle it is taken.
// Results leave one per cycle from the output register unless the output stalls, so a good
// frame (29 bytes with twelve words) yields its twelve results while the next frame arrives.
// The input stalls only when both word banks still feed the output or the job queue is
// full at the last header byte or the checksum byte. Reset is synchronous and active low
// and needs no clearing pass; the word banks are always written before they are read.
module sensor_response_frame_parser_core
    import srfp_pkg::*;
#(
    parameter int WORD_COUNT = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [IDX_W-1:0]     o_word_index,
    output logic [WORD_W-1:0]    o_word_value,
    output logic [STATUS_W-1:0]  o_frame_status,
    output logic                 o_last_of_frame,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    // Configuration registers. They are sampled live by the front: the start byte and command
    // as those header bytes arrive, the command, sizes and seed at the last header byte.
    logic [BYTE_W-1:0] r_start_byte;
    logic [BYTE_W-1:0] r_exp_cmd;
    logic [BYTE_W-1:0] r_size_lo;
    logic [BYTE_W-1:0] r_size_hi;
    logic [WORD_W-1:0] r_seed;

    // Front to queue and back.
    logic      push;
    t_job      push_job;
    t_job      head;
    logic      q_empty;
    logic      q_full;
    logic      pop;
    t_store_wr store_wr;
    t_bank_rel bank_rel;

    // The configuration port never pushes back.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= '0;
            r_exp_cmd    <= '0;
            r_size_lo    <= '0;
            r_size_hi    <= '0;
            r_seed       <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_START_BYTE: r_start_byte <= i_cfg_data[BYTE_W-1:0];
                CFG_EXP_CMD:    r_exp_cmd    <= i_cfg_data[BYTE_W-1:0];
                CFG_SIZE_LO:    r_size_lo    <= i_cfg_data[BYTE_W-1:0];
                CFG_SIZE_HI:    r_size_hi    <= i_cfg_data[BYTE_W-1:0];
                CFG_SEED:       r_seed       <= i_cfg_data;
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    // The front parses bytes and fills one of two word banks, handing each
    // finished frame or header error to the queue as a job.
    srfp_front #(
        .WORD_COUNT(WORD_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .i_start_byte(r_start_byte),
        .i_exp_cmd   (r_exp_cmd),
        .i_size_lo   (r_size_lo),
        .i_size_hi   (r_size_hi),
        .i_seed      (r_seed),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_job  (push_job),
        .o_store_wr  (store_wr),
        .i_bank_rel  (bank_rel)
    );

    // The queue lets a header error or a finished frame wait while the back
    // is still draining an earlier frame.
    srfp_job_queue u_job_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_job(push_job),
        .i_pop     (pop),
        .o_head    (head),
        .o_empty   (q_empty),
        .o_full    (q_full)
    );

    // The back walks each job and releases its bank once the last word has
    // been copied to the output register.
    srfp_back #(
        .WORD_COUNT(WORD_COUNT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_store_wr     (store_wr),
        .i_head         (head),
        .i_q_empty      (q_empty),
        .o_pop          (pop),
        .o_bank_rel     (bank_rel),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_word_index   (o_word_index),
        .o_word_value   (o_word_value),
        .o_frame_status (o_frame_status),
        .o_last_of_frame(o_last_of_frame)
    );

endmodule

>>> rtl/srfp_job_queue.sv
// Small register FIFO carrying parsed frame jobs from the front to the back.
// Depends on srfp_pkg for the job type and depth constants.
module srfp_job_queue
    import srfp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_empty,
    output logic o_full
);

    t_job                  r_mem [JOBQ_DEPTH];
    logic [JOBQ_PTR_W-1:0] r_wr_ptr;
    logic [JOBQ_PTR_W-1:0] r_rd_ptr;
    logic [JOBQ_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == JOBQ_CNT_W'(JOBQ_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/srfp_front.sv
// Front of the frame parser: takes received bytes, checks the header, assembles words,
// keeps the running checksum and hands finished frames to the job queue.
// Depends on srfp_pkg.
module srfp_front
    import srfp_pkg::*;
#(
    parameter int WORD_COUNT = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic [BYTE_W-1:0] i_start_byte,
    input  logic [BYTE_W-1:0] i_exp_cmd,
    input  logic [BYTE_W-1:0] i_size_lo,
    input  logic [BYTE_W-1:0] i_size_hi,
    input  logic [WORD_W-1:0] i_seed,
    input  logic              i_q_full,
    output logic              o_push,
    output t_job              o_push_job,
    output t_store_wr         o_store_wr,
    input  t_bank_rel         i_bank_rel
);

    localparam int CHECK_POS = HDR_LEN + 2 * WORD_COUNT;
    localparam int POS_W     = $clog2(CHECK_POS + 1);

    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_hdr_ok, n_hdr_ok;
    logic [BYTE_W-1:0] r_low, n_low;
    logic [WORD_W-1:0] r_acc, n_acc;
    logic              r_bank, n_bank;
    logic [1:0]        r_busy, n_busy;

    logic              accept;
    logic              at_push_pos;
    logic [POS_W-1:0]  offset;
    logic [WORD_W-1:0] word;

    assign at_push_pos = (r_pos == POS_W'(HDR_LEN - 1)) || (r_pos == POS_W'(CHECK_POS));

    // Hold off while the bank being filled still feeds the output, or while the
    // job queue is full at the last header byte or the checksum byte.
    assign o_in_stall = ((r_pos >= POS_W'(HDR_LEN)) && r_busy[r_bank])
                      || (at_push_pos && i_q_full);
    assign accept = i_in_valid && !o_in_stall;

    assign offset = r_pos - POS_W'(HDR_LEN);
    assign word   = {i_rx_byte, r_low};

    always_comb begin
        n_pos      = r_pos;
        n_hdr_ok   = r_hdr_ok;
        n_low      = r_low;
        n_acc      = r_acc;
        n_bank     = r_bank;
        n_busy     = r_busy;
        o_push     = 1'b0;
        o_push_job = '0;
        o_store_wr = '0;

        if (i_bank_rel.en) begin
            n_busy[i_bank_rel.bank] = 1'b0;
        end

        if (accept) begin
            n_pos = r_pos + 1'b1;
            if (r_pos == '0) begin
                n_hdr_ok = (i_rx_byte == i_start_byte);
            end else if (r_pos == POS_W'(1)) begin
                if (i_rx_byte != i_exp_cmd) begin
                    n_hdr_ok = 1'b0;
                end
            end else if (r_pos == POS_W'(2)) begin
                // Received size bytes are ignored.
            end else if (r_pos == POS_W'(HDR_LEN - 1)) begin
                if (!r_hdr_ok) begin
                    n_pos              = '0;
                    n_hdr_ok           = 1'b1;
                    o_push             = 1'b1;
                    o_push_job.hdr_err = 1'b1;
                end else begin
                    n_acc = i_seed - {8'd0, i_exp_cmd} - {8'd0, i_size_lo}
                          - {8'd0, i_size_hi};
                end
            end else if (r_pos < POS_W'(CHECK_POS)) begin
                if (!offset[0]) begin
                    n_low = i_rx_byte;
                end else begin
                    n_acc           = r_acc - word;
                    o_store_wr.en   = 1'b1;
                    o_store_wr.bank = r_bank;
                    o_store_wr.addr = IDX_W'(offset >> 1);
                    o_store_wr.data = word;
                end
            end else begin
                n_pos              = '0;
                n_hdr_ok           = 1'b1;
                o_push             = 1'b1;
                o_push_job.chk_err = ({8'd0, i_rx_byte} != r_acc);
                o_push_job.bank    = r_bank;
                n_busy[r_bank]     = 1'b1;
                n_bank             = !r_bank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_hdr_ok <= 1'b1;
            r_low    <= '0;
            r_acc    <= '0;
            r_bank   <= 1'b0;
            r_busy   <= '0;
        end else begin
            r_pos    <= n_pos;
            r_hdr_ok <= n_hdr_ok;
            r_low    <= n_low;
            r_acc    <= n_acc;
            r_bank   <= n_bank;
            r_busy   <= n_busy;
        end
    end

endmodule

>>> rtl/srfp_back.sv
// Back of the frame parser: holds the two word banks and turns each queued job into
// result transactions through a single output register. Depends on srfp_pkg.
module srfp_back
    import srfp_pkg::*;
#(
    parameter int WORD_COUNT = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_store_wr           i_store_wr,
    input  t_job                i_head,
    input  logic                i_q_empty,
    output logic                o_pop,
    output t_bank_rel           o_bank_rel,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [IDX_W-1:0]    o_word_index,
    output logic [WORD_W-1:0]   o_word_value,
    output logic [STATUS_W-1:0] o_frame_status,
    output logic                o_last_of_frame
);

    localparam int WIDX_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    logic [WORD_W-1:0] r_store [2][WORD_COUNT];

    logic [WIDX_W-1:0]   r_cnt;
    logic                r_out_valid;
    logic [IDX_W-1:0]    r_word_index;
    logic [WORD_W-1:0]   r_word_value;
    logic [STATUS_W-1:0] r_frame_status;
    logic                r_last_of_frame;

    logic can_load;
    logic load;
    logic cnt_last;

    always_ff @(posedge i_clk) begin
        if (i_store_wr.en) begin
            r_store[i_store_wr.bank][i_store_wr.addr[WIDX_W-1:0]] <= i_store_wr.data;
        end
    end

    assign can_load = !r_out_valid || !i_out_stall;
    assign load     = can_load && !i_q_empty;
    assign cnt_last = (r_cnt == WIDX_W'(WORD_COUNT - 1));

    assign o_pop           = load && (i_head.hdr_err || cnt_last);
    assign o_bank_rel.en   = load && !i_head.hdr_err && cnt_last;
    assign o_bank_rel.bank = i_head.bank;

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (i_head.hdr_err) begin
                r_word_index    <= '0;
                r_word_value    <= '0;
                r_frame_status  <= ST_HDR_ERR;
                r_last_of_frame <= 1'b1;
            end else begin
                r_word_index    <= IDX_W'(r_cnt);
                r_word_value    <= r_store[i_head.bank][r_cnt];
                r_frame_status  <= i_head.chk_err ? ST_CHK_ERR : ST_OK;
                r_last_of_frame <= cnt_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                if (!i_head.hdr_err) begin
                    r_cnt <= cnt_last ? '0 : r_cnt + 1'b1;
                end
            end else if (can_load) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_word_index    = r_word_index;
    assign o_word_value    = r_word_value;
    assign o_frame_status  = r_frame_status;
    assign o_last_of_frame = r_last_of_frame;

endmodule
